/* hw/rtl/descending_key_record_sorter_top_defines.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the descending key record sorter
// Each macro checks on the rising edge of clk and is disabled during rst.
// ----------------------------------------------------------------------------
`ifndef DESCENDING_KEY_RECORD_SORTER_TOP_DEFINES_SVH
`define DESCENDING_KEY_RECORD_SORTER_TOP_DEFINES_SVH

// Check a condition at every clock edge
`define DKRS_ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Check that a trigger is followed by a condition in the next cycle
`define DKRS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

/* hw/rtl/dkrs_pkg.sv */
// ----------------------------------------------------------------------------
// dkrs_pkg
// Shared constants, record layouts and controller states for the sorter.
// ----------------------------------------------------------------------------
package dkrs_pkg;

  localparam int MAX_RECORDS  = 64;
  localparam int TAG_BITS     = 16;
  localparam int SCORE_BITS   = 7;
  localparam int OUT_TAG_BITS = 16;
  localparam int NUM_SCORES   = 1 << SCORE_BITS;
  localparam int IDX_BITS     = $clog2(MAX_RECORDS);
  localparam int CNT_BITS     = $clog2(MAX_RECORDS + 1);

  // One stored record with its link to the next record of equal score
  typedef struct packed {
    logic [SCORE_BITS-1:0] score;
    logic [TAG_BITS-1:0]   tag;
    logic                  nxt_v;
    logic [IDX_BITS-1:0]   nxt;
  } cell_t;

  // One result transaction handed to the output stage
  typedef struct packed {
    logic [SCORE_BITS-1:0]   score;
    logic [OUT_TAG_BITS-1:0] tag;
    logic                    last;
    logic                    ovf;
  } result_t;

  typedef enum logic [5:0] {
    ST_LOAD     = 6'b000001,
    ST_BUILD_RD = 6'b000010,
    ST_BUILD_HD = 6'b000100,
    ST_BUILD_WR = 6'b001000,
    ST_SCAN     = 6'b010000,
    ST_EMIT     = 6'b100000
  } state_t;

endpackage

/* hw/rtl/dkrs_ram.sv */
// ----------------------------------------------------------------------------
// dkrs_ram
// Simple dual-port synchronous RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
module dkrs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64,
  localparam int AW   = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write on request
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read, hold data between reads
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* hw/rtl/dkrs_out_stage.sv */
// ----------------------------------------------------------------------------
// dkrs_out_stage
// Output register for result transactions with valid/stall handshake.
// ----------------------------------------------------------------------------
module dkrs_out_stage
  import dkrs_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    load,
  input  result_t                 res,
  output logic                    free,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic [SCORE_BITS-1:0]   out_score,
  output logic [OUT_TAG_BITS-1:0] out_tag,
  output logic                    out_last,
  output logic                    overflow
);

  result_t held;

  // Register is free when empty or when its transaction leaves this cycle
  assign free = !out_valid || !out_stall;

  // Track occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  // Capture payload
  always_ff @(posedge clk) begin
    if (load) begin
      held <= res;
    end
  end

  assign out_score = held.score;
  assign out_tag   = held.tag;
  assign out_last  = held.last;
  assign overflow  = held.ovf;

endmodule

/* hw/rtl/descending_key_record_sorter_top.sv */
// ----------------------------------------------------------------------------
// descending_key_record_sorter_top
// Collects a set of score/tag records and emits them in descending score
// order, equal scores in arrival order, with last and overflow marks.
// ----------------------------------------------------------------------------
// Records load one per cycle into a record RAM, in arrival order, until the
// transaction marked last closes the set; records beyond 64 are dropped and
// flag overflow on every result of that set. The input then stalls while a
// link pass walks the stored records from newest to oldest, taking each
// through the ST_BUILD_RD, ST_BUILD_HD and ST_BUILD_WR states and chaining
// it onto a per-score head RAM (128 entries, tracked by flip-flop valid
// bits, so no clearing pass is needed). Emission then steps the scores from
// 127 down to the lowest stored score, reads the head entry of each
// non-empty score and fetches its chain head, and delivers one result per
// cycle when the output does not stall. Loading of the next set starts as
// soon as the final result sits in the output register.
// ----------------------------------------------------------------------------
module descending_key_record_sorter_top
  import dkrs_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic [SCORE_BITS-1:0]   key_score,
  input  logic [15:0]             record_tag,
  input  logic                    set_last,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic [SCORE_BITS-1:0]   out_score,
  output logic [OUT_TAG_BITS-1:0] out_tag,
  output logic                    out_last,
  output logic                    overflow
);

`include "descending_key_record_sorter_top_defines.svh"

  localparam int CELL_BITS = $bits(cell_t);

  state_t                state;
  state_t                state_next;
  logic [CNT_BITS-1:0]   count;
  logic [CNT_BITS-1:0]   cnt_m1;
  logic [CNT_BITS-1:0]   emitted;
  logic                  ovf_seen;
  logic [IDX_BITS-1:0]   idx;
  cell_t                 cur;
  logic [SCORE_BITS-1:0] scan_s;
  logic [NUM_SCORES-1:0] hv;

  logic                  in_acc;
  logic                  store;
  logic                  out_free;
  logic                  emit_load;
  logic                  set_idle;
  result_t               res;
  cell_t                 a_rcell;

  logic                  a_we;
  logic [IDX_BITS-1:0]   a_waddr;
  cell_t                 a_wcell;
  logic                  a_re;
  logic [IDX_BITS-1:0]   a_raddr;
  logic [CELL_BITS-1:0]  a_rdata;

  logic                  b_we;
  logic [SCORE_BITS-1:0] b_waddr;
  logic [IDX_BITS-1:0]   b_wdata;
  logic                  b_re;
  logic [SCORE_BITS-1:0] b_raddr;
  logic [IDX_BITS-1:0]   b_rdata;

  assign in_stall = (state != ST_LOAD);
  assign in_acc   = in_valid && !in_stall;
  assign store    = (count != CNT_BITS'(MAX_RECORDS));
  assign cnt_m1   = CNT_BITS'(count - CNT_BITS'(1));
  assign a_rcell  = cell_t'(a_rdata);
  assign set_idle = (count == '0) && (hv == '0) && !ovf_seen;

  // Record store, arrival order, with per-score links
  dkrs_ram #(
    .WIDTH (CELL_BITS),
    .DEPTH (MAX_RECORDS)
  ) u_rec_ram (
    .clk   (clk),
    .we    (a_we),
    .waddr (a_waddr),
    .wdata (a_wcell),
    .re    (a_re),
    .raddr (a_raddr),
    .rdata (a_rdata)
  );

  // Head of the record chain for each score
  dkrs_ram #(
    .WIDTH (IDX_BITS),
    .DEPTH (NUM_SCORES)
  ) u_head_ram (
    .clk   (clk),
    .we    (b_we),
    .waddr (b_waddr),
    .wdata (b_wdata),
    .re    (b_re),
    .raddr (b_raddr),
    .rdata (b_rdata)
  );

  // Output register
  dkrs_out_stage u_out (
    .clk       (clk),
    .rst       (rst),
    .load      (emit_load),
    .res       (res),
    .free      (out_free),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_score (out_score),
    .out_tag   (out_tag),
    .out_last  (out_last),
    .overflow  (overflow)
  );

  // Build the result from the record just read
  always_comb begin
    res.score = a_rcell.score;
    res.tag   = OUT_TAG_BITS'(a_rcell.tag);
    res.last  = (emitted == cnt_m1);
    res.ovf   = ovf_seen;
  end

  // Drive RAM ports and sequence the set
  always_comb begin
    state_next    = state;
    a_we          = 1'b0;
    a_waddr       = count[IDX_BITS-1:0];
    a_wcell.score = key_score;
    a_wcell.tag   = TAG_BITS'(record_tag);
    a_wcell.nxt_v = 1'b0;
    a_wcell.nxt   = '0;
    a_re          = 1'b0;
    a_raddr       = idx;
    b_we          = 1'b0;
    b_waddr       = cur.score;
    b_wdata       = idx;
    b_re          = 1'b0;
    b_raddr       = a_rcell.score;
    emit_load     = 1'b0;
    unique case (state)
      ST_LOAD: begin
        a_we = in_acc && store;
        if (in_acc && set_last) begin
          state_next = ST_BUILD_RD;
        end
      end
      ST_BUILD_RD: begin
        a_re       = 1'b1;
        state_next = ST_BUILD_HD;
      end
      ST_BUILD_HD: begin
        b_re       = 1'b1;
        state_next = ST_BUILD_WR;
      end
      ST_BUILD_WR: begin
        // Prepend this record to its score chain
        a_we          = 1'b1;
        a_waddr       = idx;
        a_wcell.score = cur.score;
        a_wcell.tag   = cur.tag;
        a_wcell.nxt_v = hv[cur.score];
        a_wcell.nxt   = b_rdata;
        b_we          = 1'b1;
        state_next    = (idx == '0) ? ST_SCAN : ST_BUILD_RD;
      end
      ST_SCAN: begin
        b_raddr = scan_s;
        if (hv[scan_s]) begin
          b_re       = 1'b1;
          state_next = ST_EMIT;
        end
      end
      ST_EMIT: begin
        // First cycle after a head read fetches the chain head
        if (!cur.nxt_v) begin
          a_re    = 1'b1;
          a_raddr = b_rdata;
        end else if (out_free) begin
          emit_load = 1'b1;
          if (res.last) begin
            state_next = ST_LOAD;
          end else if (a_rcell.nxt_v) begin
            a_re    = 1'b1;
            a_raddr = a_rcell.nxt;
          end else begin
            state_next = ST_SCAN;
          end
        end
      end
      default: begin
        state_next = ST_LOAD;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_LOAD;
      count    <= '0;
      emitted  <= '0;
      ovf_seen <= 1'b0;
      hv       <= '0;
    end else begin
      state <= state_next;
      if (state == ST_LOAD && in_acc) begin
        if (store) begin
          count <= CNT_BITS'(count + CNT_BITS'(1));
        end else begin
          ovf_seen <= 1'b1;
        end
      end
      if (state == ST_BUILD_WR) begin
        hv[cur.score] <= 1'b1;
      end
      if (emit_load) begin
        if (res.last) begin
          count    <= '0;
          emitted  <= '0;
          ovf_seen <= 1'b0;
          hv       <= '0;
        end else begin
          emitted <= CNT_BITS'(emitted + CNT_BITS'(1));
        end
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    unique case (state)
      ST_LOAD: begin
        if (in_acc && set_last) begin
          idx <= store ? count[IDX_BITS-1:0] : cnt_m1[IDX_BITS-1:0];
        end
      end
      ST_BUILD_RD: begin
      end
      ST_BUILD_HD: begin
        cur <= a_rcell;
      end
      ST_BUILD_WR: begin
        idx    <= IDX_BITS'(idx - IDX_BITS'(1));
        scan_s <= '1;
      end
      ST_SCAN: begin
        // Mark that the chain head is not yet fetched
        cur.nxt_v <= 1'b0;
        if (!hv[scan_s]) begin
          scan_s <= SCORE_BITS'(scan_s - SCORE_BITS'(1));
        end
      end
      ST_EMIT: begin
        if (!cur.nxt_v) begin
          cur.nxt_v <= 1'b1;
        end else if (emit_load && !res.last && !a_rcell.nxt_v) begin
          scan_s <= SCORE_BITS'(scan_s - SCORE_BITS'(1));
        end
      end
      default: begin
      end
    endcase
  end

  // Checks
  `DKRS_ASSERT_ALWAYS(a_count_bound, count <= CNT_BITS'(MAX_RECORDS), "count above capacity")
  `DKRS_ASSERT_ALWAYS(a_emit_range, (state != ST_EMIT) || (emitted < count), "emit past count")
  `DKRS_ASSERT_NEXT(a_set_clear, emit_load && res.last, set_idle, "set not cleared")
  `DKRS_ASSERT_NEXT(a_out_load, emit_load, out_valid, "output register lost a result")

endmodule
